FILE: sv/lser_pkg.sv
`timescale 1ns / 1ps
package lser_pkg;
	localparam int LED_COUNT_DEF = 10;
	localparam logic [7:0] MAX_BRIGHT_RST = 8'd48;
	localparam logic [1:0] BASE_PAT_RST = 2'd3;

	localparam logic [1:0] REG_MAX_BRIGHT = 2'd0;
	localparam logic [1:0] REG_BASE_PAT = 2'd1;

	localparam logic [2:0] FX_BUMP = 3'd0;
	localparam logic [2:0] FX_COLLECT = 3'd1;
	localparam logic [2:0] FX_WIN = 3'd2;
	localparam logic [2:0] FX_SWEEP_LR = 3'd3;
	localparam logic [2:0] FX_SWEEP_RL = 3'd4;
	localparam logic [2:0] FX_GATHER = 3'd5;
	localparam logic [2:0] FX_SPREAD = 3'd6;
	localparam logic [2:0] FX_FLASH = 3'd7;

	localparam logic [1:0] BP_OFF = 2'd0;
	localparam logic [1:0] BP_NEAR = 2'd1;
	localparam logic [1:0] BP_IDLE = 2'd2;
	localparam logic [1:0] BP_AMBIENT = 2'd3;

	typedef struct packed {
		logic start;    // latch frame parameters for a new tick
		logic pix_go;   // render pixel at current index
		logic prep;     // derive per-frame values from the latched ones
	} ctl_cmd_t;

	typedef struct packed {
		logic last;     // current pixel is the last one
	} ctl_sts_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic logic [6:0] fx_len(input logic [2:0] k);
		logic [6:0] v;
		begin
			unique case (k)
				FX_BUMP: v = 7'd6;
				FX_COLLECT: v = 7'd10;
				FX_WIN: v = 7'd64;
				FX_SWEEP_LR: v = 7'd18;
				FX_SWEEP_RL: v = 7'd18;
				FX_GATHER: v = 7'd20;
				FX_SPREAD: v = 7'd20;
				default: v = 7'd10;
			endcase
			return v;
		end
	endfunction

	function automatic logic [7:0] qsin(input logic [6:0] j);
		logic [7:0] v;
		begin
			unique case (j)
				7'd0: v = 8'd0; 7'd1: v = 8'd6; 7'd2: v = 8'd13; 7'd3: v = 8'd19;
				7'd4: v = 8'd25; 7'd5: v = 8'd31; 7'd6: v = 8'd37; 7'd7: v = 8'd44;
				7'd8: v = 8'd50; 7'd9: v = 8'd56; 7'd10: v = 8'd62; 7'd11: v = 8'd68;
				7'd12: v = 8'd74; 7'd13: v = 8'd80; 7'd14: v = 8'd86; 7'd15: v = 8'd92;
				7'd16: v = 8'd98; 7'd17: v = 8'd103; 7'd18: v = 8'd109; 7'd19: v = 8'd115;
				7'd20: v = 8'd120; 7'd21: v = 8'd126; 7'd22: v = 8'd131; 7'd23: v = 8'd136;
				7'd24: v = 8'd142; 7'd25: v = 8'd147; 7'd26: v = 8'd152; 7'd27: v = 8'd157;
				7'd28: v = 8'd162; 7'd29: v = 8'd167; 7'd30: v = 8'd171; 7'd31: v = 8'd176;
				7'd32: v = 8'd180; 7'd33: v = 8'd185; 7'd34: v = 8'd189; 7'd35: v = 8'd193;
				7'd36: v = 8'd197; 7'd37: v = 8'd201; 7'd38: v = 8'd205; 7'd39: v = 8'd208;
				7'd40: v = 8'd212; 7'd41: v = 8'd215; 7'd42: v = 8'd219; 7'd43: v = 8'd222;
				7'd44: v = 8'd225; 7'd45: v = 8'd228; 7'd46: v = 8'd231; 7'd47: v = 8'd233;
				7'd48: v = 8'd236; 7'd49: v = 8'd238; 7'd50: v = 8'd240; 7'd51: v = 8'd242;
				7'd52: v = 8'd244; 7'd53: v = 8'd246; 7'd54: v = 8'd247; 7'd55: v = 8'd249;
				7'd56: v = 8'd250; 7'd57: v = 8'd251; 7'd58: v = 8'd252; 7'd59: v = 8'd253;
				7'd60: v = 8'd254; 7'd61: v = 8'd254; 7'd62: v = 8'd255; 7'd63: v = 8'd255;
				default: v = 8'd255;
			endcase
			return v;
		end
	endfunction

	// x/255 for x < 65536 via reciprocal and one correction
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [24:0] p;
		logic [8:0] q;
		logic [16:0] rem;
		begin
			p = 25'(x) * 25'd257;
			q = p[24:16];
			rem = 17'(x) - 17'(q) * 17'd255;
			if (rem >= 17'd255) q = q + 9'd1;
			return q[7:0];
		end
	endfunction
endpackage

FILE: sv/lser_if.sv
`timescale 1ns / 1ps
interface lser_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [2:0] effect_id;
	modport source(output valid, mode, effect_id, input ready);
	modport sink(input valid, mode, effect_id, output ready);
endinterface

interface lser_out_if;
	logic valid;
	logic ready;
	logic [3:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic last_pixel;
	modport source(output valid, pixel_index, red, green, blue, last_pixel, input ready);
	modport sink(input valid, pixel_index, red, green, blue, last_pixel, output ready);
endinterface

FILE: sv/led_strip_effect_renderer_unit.sv
`timescale 1ns / 1ps
// LED strip effect renderer.
// Input channel in_ch: mode 0 is a frame tick, mode 1 a trigger for effect_id.
// A trigger is taken while idle and produces no word. A tick produces
// LED_COUNT output words on out_ch, pixel 0 first, last_pixel set on the final.
// Config: cfg_we/cfg_index/cfg_data; 0 max_brightness, 1 base_pattern.
// Timing: accepting a tick latches frame values, a setup state derives the
// per-frame values, then one pixel per cycle is rendered into the output
// register when not stalled; in_ready is low until the last pixel is rendered.
// If the receiver stalls the render loop holds at the current pixel.
// Reset: brightness 48, ambient breathing, no effect, tick counter zero.
module led_strip_effect_renderer_unit #(
	parameter int LED_COUNT = lser_pkg::LED_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	lser_in_if.sink in_ch,
	lser_out_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);
	lser_pkg::ctl_cmd_t cmd;
	lser_pkg::ctl_sts_t sts;
	logic out_free;

	lser_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_mode(in_ch.mode),
		.in_ready(in_ch.ready), .out_free(out_free), .sts(sts), .cmd(cmd)
	);

	lser_dp #(.LED_COUNT(LED_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_ch.valid && in_ch.ready),
		.in_mode(in_ch.mode), .in_effect_id(in_ch.effect_id), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
		.out_free(out_free), .out_ch(out_ch)
	);
endmodule

FILE: sv/lser_ctrl.sv
`timescale 1ns / 1ps
module lser_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_mode,
	output logic in_ready,
	input logic out_free,
	input lser_pkg::ctl_sts_t sts,
	output lser_pkg::ctl_cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_PIX = 2'd2;

	logic [1:0] state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.start = (state_q == ST_IDLE) && in_valid && !in_mode;
		cmd.pix_go = (state_q == ST_PIX) && out_free;
		cmd.prep = (state_q == ST_PREP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.start) state_q <= ST_PREP;
				ST_PREP: state_q <= ST_PIX;
				ST_PIX: if (cmd.pix_go && sts.last) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_PREP) else $error("start lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_go && sts.last |=> in_ready) else $error("frame end lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.start && cmd.pix_go)) else $error("overlap");
endmodule

FILE: sv/lser_dp.sv
`timescale 1ns / 1ps
module lser_dp #(
	parameter int LED_COUNT = lser_pkg::LED_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic in_mode,
	input logic [2:0] in_effect_id,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data,
	input lser_pkg::ctl_cmd_t cmd,
	output lser_pkg::ctl_sts_t sts,
	output logic out_free,
	lser_out_if.source out_ch
);
	localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int HALF = LED_COUNT / 2;
	localparam logic [16:0] RCP_N = 17'(65536 / LED_COUNT);
	localparam logic [16:0] RCP_5 = 17'(65536 / 5);
	localparam logic [16:0] RCP_6 = 17'(65536 / 6);
	localparam logic [16:0] RCP_18 = 17'(65536 / 18);
	localparam logic [16:0] RCP_20 = 17'(65536 / 20);
	localparam logic [16:0] RCP_60 = 17'(65536 / 60);

	// x/d for x < 2^16: r = floor(2^16/d) lands on q or q-1, one correction
	function automatic logic [15:0] udiv_rc(input logic [15:0] x, input logic [15:0] d,
		input logic [16:0] r);
		logic [31:0] p;
		logic [15:0] q;
		logic [31:0] rem;
		begin
			p = 32'(x) * 32'(r);
			q = p[31:16];
			rem = 32'(x) - 32'(q) * 32'(d);
			if (rem >= 32'(d)) q = q + 16'd1;
			return q;
		end
	endfunction

	// x/5100 for x < 2^20, reciprocal from below and one correction
	function automatic logic [7:0] div5100(input logic [19:0] x);
		logic [31:0] p;
		logic [11:0] q;
		logic [20:0] rem;
		begin
			p = 32'(x) * 32'd3289;
			q = 12'(p >> 24);
			rem = 21'(x) - 21'(q) * 21'd5100;
			if (rem >= 21'd5100) q = q + 12'd1;
			return q[7:0];
		end
	endfunction

	logic [7:0] maxb_q;
	logic [1:0] bpat_q;
	logic act_q;
	logic [2:0] kind_q;
	logic [6:0] frame_q;
	logic [15:0] tick_q;

	// frame-level latched values
	logic fx_s1;
	logic [2:0] kind_s1;
	logic [6:0] f_s1;
	logic [11:0] wv_s1;
	lser_pkg::rgb_t base_s1;
	lser_pkg::rgb_t fxc_q;
	logic [6:0] head_q, step_q;
	logic [IW-1:0] idx_q;
	logic [2:0] hreg_q;
	logic [5:0] hrem_q;

	// breathing weight, taken at tick accept
	logic [15:0] bprod;
	logic [7:0] sidx;
	logic [7:0] sabs;
	logic [11:0] wv;

	always_comb begin
		bprod = (bpat_q == lser_pkg::BP_IDLE) ? 16'(tick_q * 16'd626) : 16'(tick_q * 16'd1252);
		sidx = bprod[15:8];
		sabs = sidx[6] ? lser_pkg::qsin(7'd64 - {1'b0, sidx[5:0]})
			: lser_pkg::qsin({1'b0, sidx[5:0]});
		if (bpat_q == lser_pkg::BP_IDLE) begin
			wv = sidx[7] ? 12'(12'd1020 - 12'(sabs)) : 12'(12'd1020 + 12'(sabs));
		end else begin
			wv = sidx[7] ? 12'(12'd3060 - 12'(sabs)) : 12'(12'd3060 + 12'(sabs));
		end
	end

	// per-frame values, registered in the setup cycle
	lser_pkg::rgb_t base_c;
	lser_pkg::rgb_t fxc_c;
	logic [13:0] fn;
	logic [15:0] qn;
	logic [15:0] q18;
	logic [6:0] hmod;
	logic [6:0] step_c;
	logic [10:0] x9;
	logic [4:0] q60;
	logic [2:0] hreg_c;
	logic [5:0] hrem_c;
	logic [7:0] e;
	logic [6:0] ad;

	always_comb begin
		// C*w/5100 with w<=3315, C<=255: products fit 20 bits
		unique case (bpat_q)
			lser_pkg::BP_OFF: base_c = '0;
			lser_pkg::BP_NEAR: base_c = '{8'h9F, 8'hD0, 8'h6A};
			default: base_c = '{div5100(20'(wv_s1) * 20'd255), div5100(20'(wv_s1) * 20'h9E),
				div5100(20'(wv_s1) * 20'h3F)};
		endcase
		fn = 14'(f_s1) * 14'(LED_COUNT);
		qn = udiv_rc(16'(f_s1), 16'(LED_COUNT), RCP_N);
		hmod = 7'(16'(f_s1) - qn * 16'(LED_COUNT));
		q18 = udiv_rc(16'(fn), 16'd18, RCP_18);
		step_c = 7'(udiv_rc(16'(f_s1) * 16'(HALF), 16'd20, RCP_20));
		// starting hue 9f mod 360 split into 60-degree region and remainder
		x9 = 11'(f_s1) * 11'd9;
		q60 = 5'(udiv_rc(16'(x9), 16'd60, RCP_60));
		priority if (q60 >= 5'd18) hreg_c = 3'(q60 - 5'd18);
		else if (q60 >= 5'd12) hreg_c = 3'(q60 - 5'd12);
		else if (q60 >= 5'd6) hreg_c = 3'(q60 - 5'd6);
		else hreg_c = 3'(q60);
		hrem_c = 6'(x9 - 11'(q60) * 11'd60);
		ad = (f_s1 > 7'd5) ? 7'(f_s1 - 7'd5) : 7'(7'd5 - f_s1);
		if (kind_s1 == lser_pkg::FX_FLASH) begin
			e = (f_s1 <= 7'd10) ? 8'(7'd5 - ad) : 8'd0;
			fxc_c = '{8'(udiv_rc(16'(e) * 16'hFF, 16'd5, RCP_5)),
				8'(udiv_rc(16'(e) * 16'hE8, 16'd5, RCP_5)),
				8'(udiv_rc(16'(e) * 16'hC0, 16'd5, RCP_5))};
		end else begin
			e = (f_s1 <= 7'd6) ? 8'(7'd6 - f_s1) : 8'd0;
			fxc_c = '{8'(udiv_rc(16'(e) * 16'd255, 16'd6, RCP_6)),
				8'(udiv_rc(16'(e) * 16'd200, 16'd6, RCP_6)),
				8'(udiv_rc(16'(e) * 16'd120, 16'd6, RCP_6))};
		end
	end

	// per-pixel colour
	lser_pkg::rgb_t px;
	logic [6:0] pi;
	logic [7:0] ht;
	logic is_gold, is_tail;
	logic [7:0] a_s;

	always_comb begin
		pi = 7'(idx_q);
		is_gold = 1'b0;
		is_tail = 1'b0;
		px = '0;
		// 255*rem/60 == 17*rem/4
		ht = 8'((10'(hrem_q) * 10'd17) >> 2);
		a_s = 8'(HALF - 1) - {1'b0, step_q};
		unique case (kind_s1)
			lser_pkg::FX_BUMP, lser_pkg::FX_FLASH: px = fxc_q;
			lser_pkg::FX_WIN: begin
				unique case (hreg_q)
					3'd0: px = '{8'd255, ht, 8'd0};
					3'd1: px = '{8'(8'd255 - ht), 8'd255, 8'd0};
					3'd2: px = '{8'd0, 8'd255, ht};
					3'd3: px = '{8'd0, 8'(8'd255 - ht), 8'd255};
					3'd4: px = '{ht, 8'd0, 8'd255};
					default: px = '{8'd255, 8'd0, 8'(8'd255 - ht)};
				endcase
			end
			lser_pkg::FX_COLLECT: begin
				is_gold = (pi == head_q);
				is_tail = (pi == ((head_q == 7'(LED_COUNT - 1)) ? 7'd0 : 7'(head_q + 7'd1)));
			end
			lser_pkg::FX_SWEEP_LR: begin
				is_gold = (pi == head_q);
				is_tail = (head_q != 7'd0) && (pi == 7'(head_q - 7'd1));
			end
			lser_pkg::FX_SWEEP_RL: begin
				// head_q holds n-1-f*n/18, may be negative in 7 bits (wraps, never matches)
				is_gold = (pi == head_q);
				is_tail = (pi == 7'(head_q + 7'd1));
			end
			lser_pkg::FX_GATHER: begin
				is_gold = (step_q < 7'(HALF)) && ((pi == step_q) ||
					(pi == 7'(LED_COUNT - 1) - step_q));
				is_tail = (step_q >= 7'd1) && ((pi == 7'(step_q - 7'd1)) ||
					(pi == 7'(7'(LED_COUNT) - step_q)));
			end
			default: begin
				// spread: a = half-1-step
				is_gold = !a_s[7] && (8'(pi) == a_s || 8'(pi) == 8'(LED_COUNT - 1) - a_s);
				is_tail = ($signed(a_s) >= -8'sd1) && (8'(a_s + 8'd1) < 8'(HALF)) &&
					(8'(pi) == 8'(a_s + 8'd1) || 8'(pi) == 8'(8'(LED_COUNT - 2) - a_s));
			end
		endcase
		if (kind_s1 != lser_pkg::FX_BUMP && kind_s1 != lser_pkg::FX_FLASH &&
			kind_s1 != lser_pkg::FX_WIN) begin
			if (is_tail) px = '{8'h80, 8'h68, 8'h10};
			else if (is_gold) px = '{8'hFF, 8'hD2, 8'h3F};
			else px = '{8'h20, 8'h18, 8'h00};
		end
		// collect: tail is tested before gold, so tail wins; sweeps/gather/spread same order
		if (!fx_s1) px = base_s1;
	end

	logic ov_q;
	logic [3:0] pidx_q;
	lser_pkg::rgb_t oc_q;
	logic last_q;
	assign out_free = !ov_q || out_ch.ready;
	assign sts.last = (idx_q == IW'(LED_COUNT - 1));

	assign out_ch.valid = ov_q;
	assign out_ch.pixel_index = pidx_q;
	assign out_ch.red = oc_q.r;
	assign out_ch.green = oc_q.g;
	assign out_ch.blue = oc_q.b;
	assign out_ch.last_pixel = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxb_q <= lser_pkg::MAX_BRIGHT_RST;
			bpat_q <= lser_pkg::BASE_PAT_RST;
			act_q <= 1'b0;
			kind_q <= '0;
			frame_q <= '0;
			tick_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == lser_pkg::REG_MAX_BRIGHT) maxb_q <= cfg_data;
			if (cfg_we && cfg_index == lser_pkg::REG_BASE_PAT) bpat_q <= cfg_data[1:0];
			if (in_fire && in_mode) begin
				kind_q <= in_effect_id;
				frame_q <= '0;
				act_q <= 1'b1;
			end
			if (cmd.start) begin
				tick_q <= tick_q + 16'd1;
				if (act_q) begin
					frame_q <= frame_q + 7'd1;
					if (!(frame_q < lser_pkg::fx_len(kind_q))) act_q <= 1'b0;
				end
			end
			if (cmd.pix_go) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			fx_s1 <= act_q;
			kind_s1 <= kind_q;
			f_s1 <= frame_q;
			wv_s1 <= wv;
			idx_q <= '0;
		end else if (cmd.prep) begin
			base_s1 <= base_c;
			fxc_q <= fxc_c;
			unique case (kind_s1)
				lser_pkg::FX_COLLECT: head_q <= hmod;
				lser_pkg::FX_SWEEP_RL: head_q <= 7'(7'(LED_COUNT - 1) - 7'(q18));
				default: head_q <= 7'(q18);
			endcase
			step_q <= step_c;
			hreg_q <= hreg_c;
			hrem_q <= hrem_c;
		end else if (cmd.pix_go) begin
			pidx_q <= 4'(idx_q);
			last_q <= sts.last;
			oc_q <= '{lser_pkg::div255(16'(px.r) * 16'(maxb_q)),
				lser_pkg::div255(16'(px.g) * 16'(maxb_q)),
				lser_pkg::div255(16'(px.b) * 16'(maxb_q))};
			idx_q <= sts.last ? '0 : IW'(idx_q + 1'b1);
			// hue advances 36 degrees per pixel
			if (hrem_q >= 6'd24) begin
				hrem_q <= 6'(hrem_q - 6'd24);
				hreg_q <= (hreg_q == 3'd5) ? 3'd0 : 3'(hreg_q + 3'd1);
			end else begin
				hrem_q <= 6'(hrem_q + 6'd36);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_go |=> out_ch.valid) else $error("word dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.pixel_index <= 4'(LED_COUNT - 1) || LED_COUNT > 16)
		else $error("bad index");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_go && sts.last |=> out_ch.last_pixel) else $error("last mark");
endmodule

FILE: verif/lser_if.sv
`timescale 1ns / 1ps

FILE: verif/led_strip_effect_renderer_unit_test.sv
`timescale 1ns / 1ps
module led_strip_effect_renderer_unit_test;
	localparam int NLED = 10;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic mode;
		logic [2:0] effect_id;
	} cmd_t;

	typedef struct packed {
		logic [3:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	lser_in_if in_ch();
	lser_out_if out_ch();

	led_strip_effect_renderer_unit #(.LED_COUNT(NLED)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow of the block state
	logic [7:0] m_bright;
	logic [1:0] m_pattern;
	logic m_active;
	logic [2:0] m_kind;
	logic [6:0] m_frame;
	logic [15:0] m_tick;

	cmd_t pending_cmds[$];
	pixel_t expected_pixels[$];
	int errors = 0;
	int idle_pct = 11;
	bit hold_sink = 0;
	int idle_cycles = 0;

	function automatic int sine_at(int idx);
		int j;
		j = idx & 63;
		case ((idx >> 6) & 3)
			0: return lser_pkg::qsin(7'(j));
			1: return lser_pkg::qsin(7'(64 - j));
			2: return -int'(lser_pkg::qsin(7'(j)));
			default: return -int'(lser_pkg::qsin(7'(64 - j)));
		endcase
	endfunction

	function automatic int effect_length(int k);
		case (k)
			0: return 6;
			1: return 10;
			2: return 64;
			3, 4: return 18;
			5, 6: return 20;
			default: return 10;
		endcase
	endfunction

	function automatic void hue_color(int h, output int r, output int g, output int b);
		int t, q;
		t = 255 * (h % 60) / 60;
		q = 255 - t;
		case (h / 60)
			0: begin r = 255; g = t; b = 0; end
			1: begin r = q; g = 255; b = 0; end
			2: begin r = 0; g = 255; b = t; end
			3: begin r = 0; g = q; b = 255; end
			4: begin r = t; g = 0; b = 255; end
			default: begin r = 255; g = 0; b = q; end
		endcase
	endfunction

	// renders one tick and queues its words
	task automatic render_tick();
		int px[NLED][3];
		int f, half, head, step, a, e, mul, k, w, r, g, b;
		pixel_t p;
		bit more;
		half = NLED / 2;
		if (m_active) begin
			f = m_frame;
			more = f < effect_length(m_kind);
			for (int i = 0; i < NLED; i++) px[i] = '{32, 24, 0};
			case (m_kind)
				lser_pkg::FX_BUMP: begin
					e = (f <= 6) ? 6 - f : 0;
					for (int i = 0; i < NLED; i++) px[i] = '{255*e/6, 200*e/6, 120*e/6};
				end
				lser_pkg::FX_COLLECT: begin
					head = f % NLED;
					px[head] = '{255, 210, 63};
					px[(head + 1) % NLED] = '{128, 104, 16};
				end
				lser_pkg::FX_WIN: begin
					for (int i = 0; i < NLED; i++) begin
						hue_color((i * 36 + f * 9) % 360, r, g, b);
						px[i] = '{r, g, b};
					end
				end
				lser_pkg::FX_SWEEP_LR, lser_pkg::FX_SWEEP_RL: begin
					head = f * NLED / 18;
					if (m_kind == lser_pkg::FX_SWEEP_RL) head = NLED - 1 - head;
					if (head >= 0 && head < NLED) px[head] = '{255, 210, 63};
					a = (m_kind == lser_pkg::FX_SWEEP_LR) ? head - 1 : head + 1;
					if (a >= 0 && a < NLED) px[a] = '{128, 104, 16};
				end
				lser_pkg::FX_GATHER: begin
					step = f * half / 20;
					if (step < half) begin
						px[step] = '{255, 210, 63};
						px[NLED - 1 - step] = '{255, 210, 63};
					end
					if (step >= 1 && step - 1 < NLED) begin
						px[step - 1] = '{128, 104, 16};
						if (NLED - step >= 0) px[NLED - step] = '{128, 104, 16};
					end
				end
				lser_pkg::FX_SPREAD: begin
					step = f * half / 20;
					a = half - 1 - step;
					if (a >= 0 && a < half) begin
						px[a] = '{255, 210, 63};
						px[NLED - 1 - a] = '{255, 210, 63};
					end
					if (a + 1 >= 0 && a + 1 < half) begin
						px[a + 1] = '{128, 104, 16};
						px[NLED - 2 - a] = '{128, 104, 16};
					end
				end
				default: begin
					e = (f <= 10) ? 5 - (f > 5 ? f - 5 : 5 - f) : 0;
					for (int i = 0; i < NLED; i++) px[i] = '{255*e/5, 232*e/5, 192*e/5};
				end
			endcase
			m_frame = m_frame + 7'd1;
			if (!more) m_active = 1'b0;
		end else begin
			case (m_pattern)
				lser_pkg::BP_OFF: for (int i = 0; i < NLED; i++) px[i] = '{0, 0, 0};
				lser_pkg::BP_NEAR: for (int i = 0; i < NLED; i++) px[i] = '{159, 208, 106};
				default: begin
					mul = (m_pattern == lser_pkg::BP_IDLE) ? 626 : 1252;
					k = (m_pattern == lser_pkg::BP_IDLE) ? 1020 : 3060;
					w = k + sine_at(((int'(m_tick) * mul) & 16'hFFFF) >> 8);
					for (int i = 0; i < NLED; i++)
						px[i] = '{255*w/5100, 158*w/5100, 63*w/5100};
				end
			endcase
		end
		m_tick = m_tick + 16'd1;
		for (int i = 0; i < NLED; i++) begin
			p.idx = 4'(i);
			p.r = 8'(px[i][0] * m_bright / 255);
			p.g = 8'(px[i][1] * m_bright / 255);
			p.b = 8'(px[i][2] * m_bright / 255);
			p.last = (i == NLED - 1);
			expected_pixels.push_back(p);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.mode <= 1'b0;
			in_ch.effect_id <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.mode) begin
					m_kind = in_ch.effect_id;
					m_frame = '0;
					m_active = 1'b1;
				end else begin
					render_tick();
				end
				void'(pending_cmds.pop_front());
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.mode <= pending_cmds[0].mode;
					in_ch.effect_id <= pending_cmds[0].effect_id;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				idle_cycles <= 0;
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected word idx=%0d rgb=%0d,%0d,%0d last=%0b", $time,
						out_ch.pixel_index, out_ch.red, out_ch.green, out_ch.blue,
						out_ch.last_pixel);
				end else begin
					want = expected_pixels.pop_front();
					if (out_ch.pixel_index !== want.idx || out_ch.red !== want.r ||
						out_ch.green !== want.g || out_ch.blue !== want.b ||
						out_ch.last_pixel !== want.last) begin
						errors++;
						$display("%0t: expected idx=%0d rgb=%0d,%0d,%0d last=%0b, got idx=%0d rgb=%0d,%0d,%0d last=%0b",
							$time, want.idx, want.r, want.g, want.b, want.last,
							out_ch.pixel_index, out_ch.red, out_ch.green, out_ch.blue,
							out_ch.last_pixel);
					end
				end
			end else if (in_ch.valid && in_ch.ready) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			out_ch.ready <= !hold_sink && ($urandom_range(99) >= idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lser_pkg::REG_MAX_BRIGHT) m_bright = val;
		else if (idx == lser_pkg::REG_BASE_PAT) m_pattern = val[1:0];
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_pixels.size() > 0 || in_ch.valid)
			@(posedge clk);
		repeat (NLED + 4) @(posedge clk);
	endtask

	task automatic push_cmd(input logic mode, input logic [2:0] id);
		cmd_t c;
		c.mode = mode;
		c.effect_id = id;
		pending_cmds.push_back(c);
	endtask

	// an effect trigger followed by enough ticks to play it out, sometimes cut short
	task automatic push_effect(input logic [2:0] id);
		int n;
		push_cmd(1'b1, id);
		n = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : effect_length(id) + 2;
		repeat (n) push_cmd(1'b0, 3'($urandom));
	endtask

	initial begin
		m_bright = lser_pkg::MAX_BRIGHT_RST;
		m_pattern = lser_pkg::BASE_PAT_RST;
		m_active = 1'b0;
		m_kind = '0;
		m_frame = '0;
		m_tick = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: each base pattern, then each effect at full brightness
		push_cmd(1'b0, 3'd0);
		push_cmd(1'b0, 3'd7);
		wait_drained();
		for (int p = 0; p < 3; p++) begin
			write_reg(lser_pkg::REG_BASE_PAT, 8'(p));
			push_cmd(1'b0, 3'd0);
			wait_drained();
		end
		write_reg(lser_pkg::REG_MAX_BRIGHT, 8'd255);
		write_reg(lser_pkg::REG_BASE_PAT, 8'(lser_pkg::BP_OFF));
		push_cmd(1'b1, lser_pkg::FX_BUMP);
		push_cmd(1'b0, 3'd0);
		push_cmd(1'b1, lser_pkg::FX_FLASH);   // restart mid effect
		for (int e = 0; e < 8; e++) begin
			push_cmd(1'b1, 3'(e));
			push_cmd(1'b0, 3'd5);
			push_cmd(1'b0, 3'd2);
		end
		wait_drained();

		// receiver holds off while the sender keeps offering
		hold_sink = 1;
		push_effect(lser_pkg::FX_WIN);
		repeat (300) @(posedge clk);
		hold_sink = 0;
		wait_drained();

		// random phases across settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_reg(lser_pkg::REG_MAX_BRIGHT, 8'd0);
				1: write_reg(lser_pkg::REG_MAX_BRIGHT, 8'd255);
				default: write_reg(lser_pkg::REG_MAX_BRIGHT, 8'($urandom));
			endcase
			write_reg(lser_pkg::REG_BASE_PAT, 8'($urandom_range(3)));
			idle_pct = (ph == 3) ? 0 : 11;
			while (pending_cmds.size() < 20) begin
				case ($urandom_range(9))
					0: push_cmd(1'b1, 3'($urandom));
					1, 2, 3: push_cmd(1'b0, 3'($urandom));
					default: push_effect(3'($urandom));
				endcase
			end
			wait_drained();
		end
		idle_pct = 11;

		wait_drained();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

FILE: files.f
sv/lser_pkg.sv
sv/lser_if.sv
sv/lser_ctrl.sv
sv/lser_dp.sv
sv/led_strip_effect_renderer_unit.sv
verif/lser_if.sv
verif/led_strip_effect_renderer_unit_test.sv
